/* rtl/core/bbba_pkg.sv */
// Shared types and constants for the bitmap buddy block allocator.
// Depends on nothing; imported by every module under rtl/core.
package bbba_pkg;

   localparam int NumBlocks       = 32;
   localparam int MaxRun          = 16;
   localparam int DefBlockBytes   = 16;
   localparam int QueueDepth      = 2;
   localparam int NumLevels       = 4;

   localparam logic [31:0] PatLevel0 = 32'h5555_5555;
   localparam logic [31:0] PatLevel1 = 32'h3333_3333;
   localparam logic [31:0] PatLevel2 = 32'h0F0F_0F0F;
   localparam logic [31:0] PatLevel3 = 32'h00FF_00FF;
   localparam logic [31:0] PatHalf   = 32'h0000_FFFF;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_SPACE  = 2'd1,
      STATUS_BAD_SIZE  = 2'd2,
      STATUS_NOT_ALLOC = 2'd3
   } status_type;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef struct packed {
      logic       mode;
      logic [8:0] size_bytes;
      logic [4:0] start_block;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  granted_block;
      logic [8:0]  byte_offset;
      logic [31:0] free_map_out;
   } rsp_type;

   // Classified request as held in the queue
   typedef struct packed {
      mode_type    mode;
      logic        size_ok;
      logic [2:0]  level;
      logic [15:0] run_mask;
      logic [4:0]  start_block;
   } cmd_type;

   // Queue handshake towards the front end
   typedef struct packed {
      logic push;
   } q_ctrl_type;

endpackage

/* rtl/core/bbba_front.sv */
// Front end: works out block count, run mask, level and size check of a request.
// Depends on bbba_pkg.
module bbba_front #(
   parameter int BLOCK_BYTES = bbba_pkg::DefBlockBytes
) (
   input  bbba_pkg::req_type req,
   output bbba_pkg::cmd_type cmd
);
   import bbba_pkg::*;

   logic [MaxRun-1:0] thr;     // thr[k]: more than k blocks needed
   logic              too_big;

   // thermometer of ceil(size / BLOCK_BYTES) against constant thresholds
   always_comb begin
      for (int k = 0; k < MaxRun; k++) begin
         thr[k] = ({23'd0, req.size_bytes} > 32'(k * BLOCK_BYTES));
      end
      too_big = ({23'd0, req.size_bytes} > 32'(MaxRun * BLOCK_BYTES));
   end

   always_comb begin
      cmd.mode        = mode_type'(req.mode);
      cmd.size_ok     = thr[0] && !too_big;
      cmd.run_mask    = thr;
      cmd.start_block = req.start_block;
      if (thr[8]) begin
         cmd.level = 3'd4;
      end else if (thr[4]) begin
         cmd.level = 3'd3;
      end else if (thr[2]) begin
         cmd.level = 3'd2;
      end else if (thr[1]) begin
         cmd.level = 3'd1;
      end else begin
         cmd.level = 3'd0;
      end
   end

endmodule

/* rtl/core/bbba_queue.sv */
// Short command queue between front and back end; back end drains every cycle.
// Depends on bbba_pkg.
module bbba_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  bbba_pkg::q_ctrl_type ctrl_in,
   input  bbba_pkg::cmd_type    push_cmd,
   output logic                 full,
   output logic                 pop_valid,
   output bbba_pkg::cmd_type    pop_cmd
);
   import bbba_pkg::*;

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   cmd_type         entry_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   assign pop       = (count_ff != '0);
   assign pop_valid = pop;
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign full      = (count_ff == CntW'(QueueDepth));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (ctrl_in.push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(ctrl_in.push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_in.push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/bbba_back.sv */
// Back end: holds the free map, picks a start, updates the map, registers result.
// Depends on bbba_pkg.
module bbba_back #(
   parameter int BLOCK_BYTES = bbba_pkg::DefBlockBytes
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  bbba_pkg::cmd_type cmd,
   output logic              rsp_strobe,
   output bbba_pkg::rsp_type rsp
);
   import bbba_pkg::*;

   localparam logic [31:0] Pat [NumLevels] = '{PatLevel0, PatLevel1, PatLevel2, PatLevel3};

   logic [31:0] free_map_ff, free_map_in;
   logic        strobe_ff;
   rsp_type     rsp_ff, rsp_in;

   logic [31:0] lvl [NumLevels+1];
   logic [31:0] g;
   logic [31:0] cand;
   logic [31:0] narrowed;
   logic [31:0] low_bit;
   logic [4:0]  pick;
   logic [4:0]  shift;
   logic [31:0] range;
   logic [31:0] prod;

   // aligned all-free runs per level
   always_comb begin
      lvl[0] = free_map_ff;
      for (int i = 0; i < NumLevels; i++) begin
         g          = lvl[i] & (lvl[i] >> (1 << i)) & Pat[i];
         lvl[i + 1] = g | (g << (1 << i));
      end
   end

   // prefer runs inside partly used larger groups
   always_comb begin
      cand = lvl[cmd.level];
      for (int i = 0; i < NumLevels; i++) begin
         narrowed = cand & ~lvl[i + 1];
         if ((3'(i) >= cmd.level) && (narrowed != '0)) begin
            cand = narrowed;
         end
      end
      low_bit = cand & (~cand + 32'd1);
      pick[4] = (low_bit & PatHalf) == '0;
      pick[3] = (low_bit & PatLevel3) == '0;
      pick[2] = (low_bit & PatLevel2) == '0;
      pick[1] = (low_bit & PatLevel1) == '0;
      pick[0] = (low_bit & PatLevel0) == '0;
   end

   always_comb begin
      shift = (cmd.mode == MODE_FREE) ? cmd.start_block : pick;
      range = {16'd0, cmd.run_mask} << shift;
      prod  = 32'(pick) * 32'(BLOCK_BYTES);

      free_map_in          = free_map_ff;
      rsp_in.status        = STATUS_OK;
      rsp_in.granted_block = '0;
      rsp_in.byte_offset   = '0;
      if (!cmd.size_ok) begin
         rsp_in.status = STATUS_BAD_SIZE;
      end else if (cmd.mode == MODE_ALLOC) begin
         if (cand == '0) begin
            rsp_in.status = STATUS_NO_SPACE;
         end else begin
            free_map_in          = free_map_ff & ~range;
            rsp_in.granted_block = pick;
            rsp_in.byte_offset   = prod[8:0];
         end
      end else begin
         if ((free_map_ff & range) != '0) begin
            rsp_in.status = STATUS_NOT_ALLOC;
         end
         free_map_in = free_map_ff | range;
      end
      rsp_in.free_map_out = free_map_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff <= '1;
         strobe_ff   <= 1'b0;
      end else begin
         strobe_ff <= cmd_valid;
         if (cmd_valid) begin
            free_map_ff <= free_map_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

endmodule

/* rtl/core/bitmap_buddy_block_allocator.sv */
// Top level of the bitmap buddy block allocator: front end, queue, back end.
// Depends on bbba_pkg, bbba_front, bbba_queue and bbba_back.
//
//  channel   ports                       direction  transfer
//  request   start, busy, req_item       in         start high while busy low
//  response  rsp_strobe, rsp_item        out        one cycle pulse, no back-pressure
//
// A request is classified on entry (block count, run mask, level, size check)
// and written to a two-deep queue. The back end takes one queued request per
// cycle: pick and map update in that cycle, response out of a register in the
// cycle after, so the sustained rate is one request per cycle, set by the
// free-map update.
// busy is the queue full flag; as the back end drains every cycle it stays low.
// Synchronous reset sets every block free.
module bitmap_buddy_block_allocator #(
   parameter int BLOCK_BYTES = bbba_pkg::DefBlockBytes
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bbba_pkg::req_type req_item,
   output logic              rsp_strobe,
   output bbba_pkg::rsp_type rsp_item
);
   import bbba_pkg::*;

   cmd_type    front_cmd;
   cmd_type    queued_cmd;
   q_ctrl_type q_ctrl;
   logic       q_full;
   logic       q_valid;

   bbba_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
      .req (req_item),
      .cmd (front_cmd)
   );

   // request accepted when start meets a free queue slot
   assign q_ctrl.push = start && !q_full;
   assign busy        = q_full;

   bbba_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl_in   (q_ctrl),
      .push_cmd  (front_cmd),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_cmd   (queued_cmd)
   );

   bbba_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd        (queued_cmd),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_item)
   );

endmodule
